// ===== rtl/core/lmts_pkg.sv =====
// Package for the LCD mode/timing/status core: item codes, register offsets,
// timing constants and the state, item and result types. No dependencies.
package lmts_pkg;

	// item kinds
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// register offsets from 0xFF40
	localparam logic [3:0] REG_LCDC = 4'd0;
	localparam logic [3:0] REG_STAT = 4'd1;
	localparam logic [3:0] REG_SCY  = 4'd2;
	localparam logic [3:0] REG_SCX  = 4'd3;
	localparam logic [3:0] REG_LY   = 4'd4;
	localparam logic [3:0] REG_LYC  = 4'd5;
	localparam logic [3:0] REG_DMA  = 4'd6;
	localparam logic [3:0] REG_BGP  = 4'd7;
	localparam logic [3:0] REG_OBP0 = 4'd8;
	localparam logic [3:0] REG_OBP1 = 4'd9;
	localparam logic [3:0] REG_WY   = 4'd10;
	localparam logic [3:0] REG_WX   = 4'd11;

	// modes (status bits 1..0)
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	// mode lengths in clock cycles
	localparam logic [15:0] CYC_OAM    = 16'd80;
	localparam logic [15:0] CYC_DRAW   = 16'd172;
	localparam logic [15:0] CYC_HBLANK = 16'd204;
	localparam logic [15:0] CYC_VBLANK = 16'd456;

	localparam logic [7:0] LINE_LAST_VISIBLE = 8'd143;
	localparam logic [7:0] LINE_LAST_VBLANK  = 8'd153;

	// status register bits
	localparam logic [7:0] STAT_WRITE_MASK = 8'h78;
	localparam logic [7:0] STAT_MODE_CLEAR = 8'hFC;
	localparam logic [7:0] STAT_MATCH      = 8'h04;
	localparam int STAT_HBLANK_IE_BIT = 3;
	localparam int STAT_VBLANK_IE_BIT = 4;
	localparam int STAT_OAM_IE_BIT    = 5;
	localparam int STAT_LYC_IE_BIT    = 6;
	localparam int LCDC_ENABLE_BIT    = 7;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] tick_count;
		logic       draw_done;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       stat_irq;
		logic       vblank_irq;
		logic       frame_end;
		logic [1:0] mode;
		logic [7:0] line;
	} result_t;

	typedef struct packed {
		logic [7:0]       lcd_control;
		logic [7:0]       lcd_status;
		logic [7:0]       scroll_y;
		logic [7:0]       scroll_x;
		logic [7:0]       line_count;
		logic [7:0]       line_compare;
		logic [7:0]       dma_page;
		logic [2:0][7:0]  palettes;
		logic [1:0][7:0]  window_pos;
		logic [15:0]      mode_cycles;
	} state_t;

	localparam state_t STATE_RESET = '{
		lcd_control:  8'h00,
		lcd_status:   8'h04,
		scroll_y:     8'h00,
		scroll_x:     8'h00,
		line_count:   8'h00,
		line_compare: 8'h00,
		dma_page:     8'h00,
		palettes:     '0,
		window_pos:   '0,
		mode_cycles:  16'h0000
	};

endpackage

// ===== rtl/core/lmts_ifs.sv =====
// Valid/ready channel interfaces for the LCD mode/timing/status core.
// Depends on lmts_pkg for nothing but follows its field widths.
interface lmts_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [3:0] reg_index;
	logic [7:0] write_data;
	logic [7:0] tick_count;
	logic       draw_done;

	modport source (output valid, opcode, reg_index, write_data, tick_count, draw_done,
		input ready);
	modport sink (input valid, opcode, reg_index, write_data, tick_count, draw_done,
		output ready);
endinterface

interface lmts_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       stat_irq;
	logic       vblank_irq;
	logic       frame_end;
	logic [1:0] mode;
	logic [7:0] line;

	modport source (output valid, read_data, stat_irq, vblank_irq, frame_end, mode, line,
		input ready);
	modport sink (input valid, read_data, stat_irq, vblank_irq, frame_end, mode, line,
		output ready);
endinterface

// ===== rtl/core/lmts_step.sv =====
// Next-state and result logic for one item: register read/write decode,
// mode sequencer and interrupt levels. Depends on lmts_pkg.
module lmts_step (
	input  lmts_pkg::state_t  cur,
	input  lmts_pkg::item_t   item,
	output lmts_pkg::state_t  nxt,
	output lmts_pkg::result_t res
);

	logic [16:0] sum;
	logic [15:0] sat;
	logic [7:0]  ly_inc;
	logic        vb;
	logic        sirq;
	logic [7:0]  rd;
	logic        match_irq;

	assign sum    = {1'b0, cur.mode_cycles} + {9'd0, item.tick_count};
	assign sat    = sum[16] ? 16'hFFFF : sum[15:0];
	assign ly_inc = cur.line_count + 8'd1;

	always_comb begin
		nxt  = cur;
		vb   = 1'b0;
		sirq = 1'b0;
		rd   = 8'h00;
		match_irq = 1'b0;
		case (item.opcode)
			lmts_pkg::OP_TICK: begin
				nxt.mode_cycles = sat;
				case (cur.lcd_status[1:0])
					lmts_pkg::MODE_HBLANK: begin
						if (sat >= lmts_pkg::CYC_HBLANK) begin
							nxt.mode_cycles = sat - lmts_pkg::CYC_HBLANK;
							nxt.line_count  = ly_inc;
							if (ly_inc > lmts_pkg::LINE_LAST_VISIBLE) begin
								nxt.lcd_status[1:0] = lmts_pkg::MODE_VBLANK;
								vb = 1'b1;
							end else begin
								nxt.lcd_status[1:0] = lmts_pkg::MODE_OAM;
							end
						end
					end
					lmts_pkg::MODE_VBLANK: begin
						if (sat >= lmts_pkg::CYC_VBLANK) begin
							nxt.mode_cycles = sat - lmts_pkg::CYC_VBLANK;
							nxt.line_count  = ly_inc;
							if (ly_inc > lmts_pkg::LINE_LAST_VBLANK) begin
								nxt.line_count      = 8'h00;
								nxt.lcd_status[1:0] = lmts_pkg::MODE_OAM;
							end
						end
					end
					lmts_pkg::MODE_OAM: begin
						if (sat >= lmts_pkg::CYC_OAM) begin
							nxt.mode_cycles     = sat - lmts_pkg::CYC_OAM;
							nxt.lcd_status[1:0] = lmts_pkg::MODE_DRAW;
						end
					end
					default: begin
						// drawing ends only on a non-empty batch with draw_done
						if (item.tick_count != 8'd0 && item.draw_done) begin
							nxt.mode_cycles = (sat >= lmts_pkg::CYC_DRAW) ?
								sat - lmts_pkg::CYC_DRAW : 16'h0000;
							nxt.lcd_status[1:0] = lmts_pkg::MODE_HBLANK;
						end
					end
				endcase
			end
			lmts_pkg::OP_READ: begin
				case (item.reg_index)
					lmts_pkg::REG_LCDC: rd = cur.lcd_control;
					lmts_pkg::REG_STAT: rd = cur.lcd_status;
					lmts_pkg::REG_SCY:  rd = cur.scroll_y;
					lmts_pkg::REG_SCX:  rd = cur.scroll_x;
					lmts_pkg::REG_LY:   rd = cur.line_count;
					lmts_pkg::REG_LYC:  rd = cur.line_compare;
					lmts_pkg::REG_DMA:  rd = cur.dma_page;
					lmts_pkg::REG_BGP:  rd = cur.palettes[0];
					lmts_pkg::REG_OBP0: rd = cur.palettes[1];
					lmts_pkg::REG_OBP1: rd = cur.palettes[2];
					lmts_pkg::REG_WY:   rd = cur.window_pos[0];
					lmts_pkg::REG_WX:   rd = cur.window_pos[1];
					default:            rd = 8'h00;
				endcase
			end
			lmts_pkg::OP_WRITE: begin
				case (item.reg_index)
					lmts_pkg::REG_LCDC: begin
						// display switched on: restart at line 0 in OAM search
						if (!cur.lcd_control[lmts_pkg::LCDC_ENABLE_BIT] &&
								item.write_data[lmts_pkg::LCDC_ENABLE_BIT]) begin
							nxt.line_count      = 8'h00;
							nxt.mode_cycles     = 16'h0000;
							nxt.lcd_status[1:0] = lmts_pkg::MODE_OAM;
						end
						nxt.lcd_control = item.write_data;
					end
					lmts_pkg::REG_STAT: nxt.lcd_status =
						(item.write_data & lmts_pkg::STAT_WRITE_MASK) |
						(cur.lcd_status & ~(lmts_pkg::STAT_MODE_CLEAR ^ lmts_pkg::STAT_MATCH));
					lmts_pkg::REG_SCY:  nxt.scroll_y      = item.write_data;
					lmts_pkg::REG_SCX:  nxt.scroll_x      = item.write_data;
					lmts_pkg::REG_LY:   nxt.line_count    = 8'h00;
					lmts_pkg::REG_LYC:  nxt.line_compare  = item.write_data;
					lmts_pkg::REG_DMA:  nxt.dma_page      = item.write_data;
					lmts_pkg::REG_BGP:  nxt.palettes[0]   = item.write_data;
					lmts_pkg::REG_OBP0: nxt.palettes[1]   = item.write_data;
					lmts_pkg::REG_OBP1: nxt.palettes[2]   = item.write_data;
					lmts_pkg::REG_WY:   nxt.window_pos[0] = item.write_data;
					lmts_pkg::REG_WX:   nxt.window_pos[1] = item.write_data;
					default: ;
				endcase
			end
			default: ;
		endcase

		// coincidence flag refresh after ticks and writes
		if (item.opcode == lmts_pkg::OP_TICK || item.opcode == lmts_pkg::OP_WRITE) begin
			if (nxt.line_count == nxt.line_compare) begin
				nxt.lcd_status = nxt.lcd_status | lmts_pkg::STAT_MATCH;
			end else begin
				nxt.lcd_status = nxt.lcd_status & ~lmts_pkg::STAT_MATCH;
			end
		end

		match_irq = nxt.lcd_status[lmts_pkg::STAT_LYC_IE_BIT] &&
			((nxt.lcd_status & lmts_pkg::STAT_MATCH) != 8'h00);

		if (item.opcode == lmts_pkg::OP_TICK) begin
			sirq = match_irq ||
				(nxt.lcd_status[1:0] == lmts_pkg::MODE_HBLANK &&
					nxt.lcd_status[lmts_pkg::STAT_HBLANK_IE_BIT]) ||
				(nxt.lcd_status[1:0] == lmts_pkg::MODE_VBLANK &&
					nxt.lcd_status[lmts_pkg::STAT_VBLANK_IE_BIT]) ||
				(nxt.lcd_status[1:0] == lmts_pkg::MODE_OAM &&
					nxt.lcd_status[lmts_pkg::STAT_OAM_IE_BIT]);
		end else if (item.opcode == lmts_pkg::OP_WRITE) begin
			sirq = match_irq;
		end
	end

	always_comb begin
		res.read_data  = rd;
		res.stat_irq   = sirq;
		res.vblank_irq = vb;
		res.frame_end  = vb;
		res.mode       = nxt.lcd_status[1:0];
		res.line       = nxt.line_count;
	end

endmodule

// ===== rtl/core/lcd_mode_timing_status_core.sv =====
// Top level of the LCD mode/timing/status core: input register, state
// registers and result register. Depends on lmts_pkg, lmts_ifs and lmts_step.
//
// Use:
//   item   - one transfer per CPU-side event: a tick batch (cycle count plus
//            the pixel pipeline's draw_done flag), a register read or a
//            register write at offsets 0..11 from 0xFF40.
//   result - exactly one transfer per item, in order: read data (zero unless a
//            read), STAT interrupt level, V-blank pulse, frame-end pulse, and
//            the mode and line after the item.
// Path: a taken item is held in the input register, and its result is then
//   registered in the result register before it is presented.
// Throughput: one item per cycle, unless stalled; the state update is a single
//   17-bit add, one compare/subtract against the mode length and a register mux.
// Reset: arst_n clears both valid flags and puts the state registers at their
//   power-on values (status 0x04: H-blank, coincidence set, line 0).
// Stall: when result.ready is low the result register holds; the input
//   register still takes one more item, then item.ready drops until the
//   result side drains.
module lcd_mode_timing_status_core (
	input logic           clk,
	input logic           arst_n,
	lmts_item_if.sink     item,
	lmts_result_if.source result
);

	lmts_pkg::item_t   item_in;
	lmts_pkg::item_t   item_s1;
	logic              valid_s1;
	lmts_pkg::state_t  state_q;
	lmts_pkg::state_t  state_nxt;
	lmts_pkg::result_t res_nxt;
	lmts_pkg::result_t res_s2;
	logic              valid_s2;
	logic              advance;

	assign item_in.opcode     = item.opcode;
	assign item_in.reg_index  = item.reg_index;
	assign item_in.write_data = item.write_data;
	assign item_in.tick_count = item.tick_count;
	assign item_in.draw_done  = item.draw_done;

	// stage 1 moves into the result register when that register is free or draining
	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;

	lmts_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// input register payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item_in;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_nxt;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= lmts_pkg::STATE_RESET;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
		end
	end

	assign result.valid      = valid_s2;
	assign result.read_data  = res_s2.read_data;
	assign result.stat_irq   = res_s2.stat_irq;
	assign result.vblank_irq = res_s2.vblank_irq;
	assign result.frame_end  = res_s2.frame_end;
	assign result.mode       = res_s2.mode;
	assign result.line       = res_s2.line;

	// the line counter never leaves 0..153
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line_count <= lmts_pkg::LINE_LAST_VBLANK)
		else $error("line counter out of range");

	// status bit 7 reads as zero
	a_stat_bit7: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.lcd_status[7])
		else $error("status bit 7 set");

	// a V-blank pulse is always the entry into line 144 in V-blank
	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.vblank_irq |->
			res_s2.mode == lmts_pkg::MODE_VBLANK && res_s2.line == 8'd144 &&
			res_s2.frame_end)
		else $error("V-blank pulse outside V-blank entry");

	// the state holds while the result is stalled and only moves when stage 1 drains
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> $stable(state_q))
		else $error("state changed while result stalled");

endmodule
